/* hw/rtl/assert_macros.svh */
// Assertion macros for the checker file of this project.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* hw/rtl/rfrv_pkg.sv */
// Package for the remote frame to rate-limited velocity block.
// Holds widths, constants, register indexes and the pipeline stage types.
`default_nettype none

package rfrv_pkg;

    localparam int FRAME_W   = 56;
    localparam int RAW_W     = 11;
    localparam int MAG_W     = 11;
    localparam int SCALE_W   = 12;
    localparam int STEP_W    = 15;
    localparam int PROD_W    = MAG_W + SCALE_W;
    localparam int QUOT_W    = 14;
    localparam int VEL_W     = QUOT_W + 1;
    localparam int SW_W      = 2;
    localparam int BTN_W     = 6;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;

    localparam logic [RAW_W-1:0] STICK_BIAS = 11'd660;

    // Division by 660 as a multiply by ceil(2^32 / 660) and a shift by 32.
    // The result is exact for every product below 2^32 / 524.
    localparam int RECIP_SHIFT = 2 * PROD_W - QUOT_W;
    localparam logic [PROD_W-1:0] RECIP_MUL = 23'd6507527;

    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_STEP         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATION_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_SCALE         = 2'd2;

    localparam logic [STEP_W-1:0]  SLEW_STEP_RESET         = 15'd500;
    localparam logic [SCALE_W-1:0] TRANSLATION_SCALE_RESET = 12'd3000;
    localparam logic [SCALE_W-1:0] YAW_SCALE_RESET         = 12'd5;

    localparam logic [SW_W-1:0] SW_UP   = 2'd1;
    localparam logic [SW_W-1:0] SW_DOWN = 2'd2;
    localparam logic [SW_W-1:0] SW_NONE = 2'd0;

    typedef enum logic [1:0] {
        MODE_STANDBY,
        MODE_MANUAL,
        MODE_AUTO,
        MODE_TEST
    } mode_t;

    typedef struct packed {
        mode_t            mode;
        logic [SW_W-1:0]  sw4;
        logic [BTN_W-1:0] buttons;
    } side_t;

    typedef struct packed {
        logic              neg;
        logic [PROD_W-1:0] mag;
    } prod_t;

    typedef struct packed {
        prod_t x;
        prod_t y;
        prod_t yaw;
        side_t side;
    } bstage_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] x;
        logic signed [VEL_W-1:0] y;
        logic signed [VEL_W-1:0] yaw;
        side_t                   side;
    } cstage_t;

endpackage

`default_nettype wire

/* hw/rtl/rfrv_unpack_mul.sv */
// Frame unpack stage: stick fields, switch decode, buttons, and stick times scale.
// Depends on rfrv_pkg.
`default_nettype none

module rfrv_unpack_mul
    import rfrv_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               load,
    input  wire logic [FRAME_W-1:0] frame,
    input  wire logic [SCALE_W-1:0] translation_scale,
    input  wire logic [SCALE_W-1:0] yaw_scale,
    output bstage_t                 stage_reg
);

    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic [RAW_W-1:0] raw_yaw;
    logic [SW_W-1:0]  sw1;
    logic [SW_W-1:0]  sw2;
    logic             neg_x;
    logic             neg_y;
    logic             neg_yaw;
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic [MAG_W-1:0] mag_yaw;
    mode_t            mode;
    bstage_t          stage_next;

    assign raw_x   = frame[55:45];
    assign raw_y   = frame[44:34];
    assign raw_yaw = frame[33:23];
    assign sw1     = frame[22:21];
    assign sw2     = frame[20:19];

    always_comb
    begin
        neg_x   = raw_x > STICK_BIAS;
        mag_x   = neg_x ? raw_x - STICK_BIAS : STICK_BIAS - raw_x;
        neg_y   = raw_y < STICK_BIAS;
        mag_y   = neg_y ? STICK_BIAS - raw_y : raw_y - STICK_BIAS;
        neg_yaw = raw_yaw > STICK_BIAS;
        mag_yaw = neg_yaw ? raw_yaw - STICK_BIAS : STICK_BIAS - raw_yaw;
    end

    always_comb
    begin
        priority if (sw1 == SW_UP && sw2 == SW_UP)
            mode = MODE_MANUAL;
        else if (sw1 == SW_DOWN && sw2 == SW_DOWN)
            mode = MODE_AUTO;
        else if (sw1 == SW_UP && sw2 == SW_DOWN)
            mode = MODE_TEST;
        else
            mode = MODE_STANDBY;
    end

    always_comb
    begin
        stage_next.x.neg        = neg_x;
        stage_next.x.mag        = PROD_W'(mag_x) * PROD_W'(translation_scale);
        stage_next.y.neg        = neg_y;
        stage_next.y.mag        = PROD_W'(mag_y) * PROD_W'(translation_scale);
        stage_next.yaw.neg      = neg_yaw;
        stage_next.yaw.mag      = PROD_W'(mag_yaw) * PROD_W'(yaw_scale);
        stage_next.side.mode    = mode;
        stage_next.side.sw4     = frame[16:15];
        stage_next.side.buttons = {frame[7], frame[8], frame[9],
                                   frame[10], frame[11], frame[12]};
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rfrv_recip_div.sv */
// Division stage: scaled stick products divided by 660 and given their sign.
// Depends on rfrv_pkg.
`default_nettype none

module rfrv_recip_div
    import rfrv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    load,
    input  wire bstage_t stage_in,
    output cstage_t      stage_reg
);

    cstage_t stage_next;

    function automatic logic signed [VEL_W-1:0] recip_target(prod_t p);
        logic [2*PROD_W-1:0] full;
        logic [VEL_W-1:0]    quot;
        full = {{PROD_W{1'b0}}, p.mag} * {{PROD_W{1'b0}}, RECIP_MUL};
        quot = {1'b0, full[RECIP_SHIFT +: QUOT_W]};
        recip_target = p.neg ? VEL_W'(-quot) : quot;
    endfunction

    always_comb
    begin
        stage_next.x    = recip_target(stage_in.x);
        stage_next.y    = recip_target(stage_in.y);
        stage_next.yaw  = recip_target(stage_in.yaw);
        stage_next.side = stage_in.side;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rfrv_slew.sv */
// Result stage: slew limit against the previous output, sticky test submode.
// The output registers double as the previous-value state. Depends on rfrv_pkg.
`default_nettype none

module rfrv_slew
    import rfrv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  load,
    input  wire cstage_t               stage_in,
    input  wire logic [STEP_W-1:0]     slew_step,
    output logic signed [VEL_W-1:0]    velocity_x_reg,
    output logic signed [VEL_W-1:0]    velocity_y_reg,
    output logic signed [VEL_W-1:0]    velocity_yaw_reg,
    output mode_t                      mode_reg,
    output logic [SW_W-1:0]            submode_reg,
    output logic [BTN_W-1:0]           buttons_reg
);

    logic signed [VEL_W-1:0] velocity_x_next;
    logic signed [VEL_W-1:0] velocity_y_next;
    logic signed [VEL_W-1:0] velocity_yaw_next;
    logic [SW_W-1:0]         submode_next;

    function automatic logic signed [VEL_W-1:0] slew_limit(
        logic signed [VEL_W-1:0] target,
        logic signed [VEL_W-1:0] last,
        logic [STEP_W-1:0]       step
    );
        logic signed [VEL_W+1:0] target_w;
        logic signed [VEL_W+1:0] last_w;
        logic signed [VEL_W+1:0] diff;
        logic signed [VEL_W+1:0] lim;
        logic signed [VEL_W+1:0] result;
        target_w = (VEL_W+2)'(target);
        last_w   = (VEL_W+2)'(last);
        diff     = target_w - last_w;
        lim      = {{(VEL_W+2-STEP_W){1'b0}}, step};
        priority if (diff > lim)
            result = last_w + lim;
        else if (diff < -lim)
            result = last_w - lim;
        else
            result = target_w;
        slew_limit = result[VEL_W-1:0];
    endfunction

    always_comb
    begin
        velocity_x_next   = slew_limit(stage_in.x, velocity_x_reg, slew_step);
        velocity_y_next   = slew_limit(stage_in.y, velocity_y_reg, slew_step);
        velocity_yaw_next = slew_limit(stage_in.yaw, velocity_yaw_reg, slew_step);
        submode_next      = (stage_in.side.sw4 != SW_NONE) ? stage_in.side.sw4 : submode_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            velocity_x_reg   <= '0;
            velocity_y_reg   <= '0;
            velocity_yaw_reg <= '0;
            submode_reg      <= SW_NONE;
        end
        else if (load)
        begin
            velocity_x_reg   <= velocity_x_next;
            velocity_y_reg   <= velocity_y_next;
            velocity_yaw_reg <= velocity_yaw_next;
            submode_reg      <= submode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mode_reg    <= stage_in.side.mode;
            buttons_reg <= stage_in.side.buttons;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/remote_frame_to_rate_limited_velocity.sv */
// Top level of the remote frame to rate-limited velocity block.
// Depends on rfrv_pkg, rfrv_unpack_mul, rfrv_recip_div and rfrv_slew.
//
// Usage: a remote-control frame (bytes 1 to 7) enters on the input channel
// (in_valid, in_stall, frame_bytes) and one result leaves on the output
// channel (out_valid, out_stall and the six result fields) for every frame.
// A transaction completes on a rising edge where valid is high and stall is low.
// The block is a four-register pipeline: input register, stick times scale,
// division by 660 through a reciprocal multiply, and slew limiting.
// A frame passes these stages in order, and one frame is taken every cycle
// while the output side keeps up.
// When the receiver stalls, the result stays in the output register and the
// stages behind it keep filling; in_stall rises only once every stage holds
// a frame. The slew limit compares against the previously delivered velocity.
// Reset clears all stages, sets the previous velocities and the held test
// submode to zero and loads the register defaults (slew step 500,
// translation scale 3000, yaw scale 5). Configuration writes through
// cfg_we, cfg_index and cfg_data take effect at once; index 3 is ignored.
`default_nettype none

module remote_frame_to_rate_limited_velocity
    import rfrv_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_W-1:0]      cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [FRAME_W-1:0]    frame_bytes,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic signed [VEL_W-1:0]    velocity_x,
    output logic signed [VEL_W-1:0]    velocity_y,
    output logic signed [VEL_W-1:0]    velocity_yaw,
    output logic [1:0]                 chassis_mode,
    output logic [SW_W-1:0]            test_submode,
    output logic [BTN_W-1:0]           button_bits
);

    logic [STEP_W-1:0]  slew_step_reg;
    logic [SCALE_W-1:0] translation_scale_reg;
    logic [SCALE_W-1:0] yaw_scale_reg;

    logic               a_valid_reg;
    logic               b_valid_reg;
    logic               c_valid_reg;
    logic               o_valid_reg;
    logic               a_valid_next;
    logic               b_valid_next;
    logic               c_valid_next;
    logic               o_valid_next;
    logic               free_a;
    logic               free_b;
    logic               free_c;
    logic               free_o;
    logic [FRAME_W-1:0] frame_reg;

    bstage_t            b_stage;
    cstage_t            c_stage;
    mode_t              mode_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slew_step_reg         <= SLEW_STEP_RESET;
            translation_scale_reg <= TRANSLATION_SCALE_RESET;
            yaw_scale_reg         <= YAW_SCALE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SLEW_STEP:         slew_step_reg         <= cfg_data[STEP_W-1:0];
                CFG_TRANSLATION_SCALE: translation_scale_reg <= cfg_data[SCALE_W-1:0];
                CFG_YAW_SCALE:         yaw_scale_reg         <= cfg_data[SCALE_W-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        free_o       = !o_valid_reg || !out_stall;
        free_c       = !c_valid_reg || free_o;
        free_b       = !b_valid_reg || free_c;
        free_a       = !a_valid_reg || free_b;
        a_valid_next = free_a ? in_valid    : a_valid_reg;
        b_valid_next = free_b ? a_valid_reg : b_valid_reg;
        c_valid_next = free_c ? b_valid_reg : c_valid_reg;
        o_valid_next = free_o ? c_valid_reg : o_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free_a && in_valid)
        begin
            frame_reg <= frame_bytes;
        end
    end

    rfrv_unpack_mul u_unpack_mul (
        .clk               (clk),
        .load              (free_b && a_valid_reg),
        .frame             (frame_reg),
        .translation_scale (translation_scale_reg),
        .yaw_scale         (yaw_scale_reg),
        .stage_reg         (b_stage)
    );

    rfrv_recip_div u_recip_div (
        .clk       (clk),
        .load      (free_c && b_valid_reg),
        .stage_in  (b_stage),
        .stage_reg (c_stage)
    );

    rfrv_slew u_slew (
        .clk              (clk),
        .rst_n            (rst_n),
        .load             (free_o && c_valid_reg),
        .stage_in         (c_stage),
        .slew_step        (slew_step_reg),
        .velocity_x_reg   (velocity_x),
        .velocity_y_reg   (velocity_y),
        .velocity_yaw_reg (velocity_yaw),
        .mode_reg         (mode_out),
        .submode_reg      (test_submode),
        .buttons_reg      (button_bits)
    );

    assign chassis_mode = mode_out;
    assign in_stall     = !free_a;
    assign out_valid    = o_valid_reg;

endmodule

`default_nettype wire

/* hw/rtl/rfrv_checker.sv */
// Port-level checker for the remote frame to rate-limited velocity block.
// Depends on rfrv_pkg and assert_macros.svh; bound to the top level at the end of this file.
`default_nettype none
`include "assert_macros.svh"

module rfrv_checker
    import rfrv_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [14:0] velocity_x,
    input wire logic [1:0]  test_submode
);

    // A stalled result transaction stays valid and keeps its x velocity.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(velocity_x))

    // The input side backs up only when the output side is stalled.
    `ASSERT_IMPLIES(a_stall_backpressure, clk, rst_n, in_stall, out_valid && out_stall)

    // Once set, the test submode never returns to the unset code.
    `ASSERT_NEXT(a_submode_sticky, clk, rst_n, test_submode != SW_NONE, test_submode != SW_NONE)

    // The test submode changes only together with a new result.
    `ASSERT_IMPLIES(a_submode_with_result, clk, rst_n, !$stable(test_submode), out_valid)

endmodule

bind remote_frame_to_rate_limited_velocity rfrv_checker u_rfrv_checker (.*);

`default_nettype wire

/* dv/tb_top.sv */
// Testbench for remote_frame_to_rate_limited_velocity: drives remote frames and register
// settings, predicts each velocity command in a scoreboard class and checks every result.
// Depends on rfrv_pkg and the block's RTL only.
module tb_top;
    import rfrv_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [SW_W-1:0] SW_MID    = 2'd3;
    localparam logic [SW_W-1:0] SUB_CLIMB = 2'd1;
    localparam logic [SW_W-1:0] SUB_DOWN  = 2'd2;
    localparam logic [SW_W-1:0] SUB_UP    = 2'd3;
    localparam int PRESSURE_CYCLES = 80;

    typedef struct {
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic signed [VEL_W-1:0] vyaw;
        mode_t                   mode;
        logic [SW_W-1:0]         submode;
        logic [BTN_W-1:0]        buttons;
    } chassis_cmd_t;

    class chassis_cmd_tracker;
        int slew_step;
        int trans_scale;
        int yaw_scale;
        int prev_x;
        int prev_y;
        int prev_yaw;
        logic [SW_W-1:0] held_sub;
        chassis_cmd_t pending_cmds[$];
        int mismatches;

        function new();
            slew_step   = int'(SLEW_STEP_RESET);
            trans_scale = int'(TRANSLATION_SCALE_RESET);
            yaw_scale   = int'(YAW_SCALE_RESET);
            prev_x      = 0;
            prev_y      = 0;
            prev_yaw    = 0;
            held_sub    = SW_NONE;
            mismatches  = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
            case (idx)
                CFG_SLEW_STEP:         slew_step   = int'(data[STEP_W-1:0]);
                CFG_TRANSLATION_SCALE: trans_scale = int'(data[SCALE_W-1:0]);
                CFG_YAW_SCALE:         yaw_scale   = int'(data[SCALE_W-1:0]);
                default: ;
            endcase
        endfunction

        function int scaled(input int stick, input int scale);
            return (stick * scale) / int'(STICK_BIAS);
        endfunction

        function int limit_step(input int target, input int prev);
            int diff;
            diff = target - prev;
            if (diff > slew_step)
                return prev + slew_step;
            if (diff < -slew_step)
                return prev - slew_step;
            return target;
        endfunction

        function void take_frame(input logic [FRAME_W-1:0] f);
            chassis_cmd_t c;
            int bias;
            logic [SW_W-1:0] sw1;
            logic [SW_W-1:0] sw2;
            logic [SW_W-1:0] sw4;
            bias = int'(STICK_BIAS);
            prev_x   = limit_step(scaled(bias - int'(f[55:45]), trans_scale), prev_x);
            prev_y   = limit_step(scaled(int'(f[44:34]) - bias, trans_scale), prev_y);
            prev_yaw = limit_step(scaled(bias - int'(f[33:23]), yaw_scale), prev_yaw);
            sw1 = f[22:21];
            sw2 = f[20:19];
            sw4 = f[16:15];
            if (sw1 == SW_UP && sw2 == SW_UP)
                c.mode = MODE_MANUAL;
            else if (sw1 == SW_DOWN && sw2 == SW_DOWN)
                c.mode = MODE_AUTO;
            else if (sw1 == SW_UP && sw2 == SW_DOWN)
                c.mode = MODE_TEST;
            else
                c.mode = MODE_STANDBY;
            if (sw4 != SW_NONE)
                held_sub = sw4;
            c.vx      = VEL_W'(prev_x);
            c.vy      = VEL_W'(prev_y);
            c.vyaw    = VEL_W'(prev_yaw);
            c.submode = held_sub;
            c.buttons = {f[7], f[8], f[9], f[10], f[11], f[12]};
            pending_cmds.push_back(c);
        endfunction

        function void match_output(input logic signed [VEL_W-1:0] vx,
                                   input logic signed [VEL_W-1:0] vy,
                                   input logic signed [VEL_W-1:0] vyaw,
                                   input logic [1:0] mode,
                                   input logic [SW_W-1:0] submode,
                                   input logic [BTN_W-1:0] buttons);
            chassis_cmd_t c;
            if (pending_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb_top: unexpected result x %0d y %0d yaw %0d mode %0d sub %0d btn %h",
                             vx, vy, vyaw, mode, submode, buttons);
                return;
            end
            c = pending_cmds.pop_front();
            if (vx !== c.vx || vy !== c.vy || vyaw !== c.vyaw || mode !== c.mode
                    || submode !== c.submode || buttons !== c.buttons) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("tb_top: mismatch, expected x %0d y %0d yaw %0d mode %0d sub %0d btn %h",
                             c.vx, c.vy, c.vyaw, c.mode, c.submode, c.buttons);
                    $display("tb_top:           actual   x %0d y %0d yaw %0d mode %0d sub %0d btn %h",
                             vx, vy, vyaw, mode, submode, buttons);
                end
            end
        endfunction

        function int outstanding();
            return pending_cmds.size();
        endfunction

        function int failures();
            return mismatches + pending_cmds.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [FRAME_W-1:0] frame_bytes;
    logic out_valid;
    logic out_stall;
    logic signed [VEL_W-1:0] velocity_x;
    logic signed [VEL_W-1:0] velocity_y;
    logic signed [VEL_W-1:0] velocity_yaw;
    logic [1:0] chassis_mode;
    logic [SW_W-1:0] test_submode;
    logic [BTN_W-1:0] button_bits;

    logic sender_calm;
    logic receiver_calm;
    logic pressure_req;
    chassis_cmd_tracker tracker = new();

    remote_frame_to_rate_limited_velocity dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .frame_bytes  (frame_bytes),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .velocity_x   (velocity_x),
        .velocity_y   (velocity_y),
        .velocity_yaw (velocity_yaw),
        .chassis_mode (chassis_mode),
        .test_submode (test_submode),
        .button_bits  (button_bits)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [RAW_W-1:0] pick_stick();
        case ($urandom_range(0, 9))
            0: return 11'd0;
            1: return 11'd2047;
            2: return STICK_BIAS;
            3: return STICK_BIAS + RAW_W'($urandom_range(0, 6)) - 11'd3;
            4: return RAW_W'($urandom_range(0, 1320));
            default: return RAW_W'($urandom_range(0, 2047));
        endcase
    endfunction

    function automatic logic [FRAME_W-1:0] make_frame(input logic [RAW_W-1:0] raw1,
                                                      input logic [RAW_W-1:0] raw2,
                                                      input logic [RAW_W-1:0] raw3,
                                                      input logic [SW_W-1:0] sw1,
                                                      input logic [SW_W-1:0] sw2,
                                                      input logic [SW_W-1:0] sw4,
                                                      input logic [BTN_W-1:0] btn,
                                                      input logic [10:0] junk);
        logic [FRAME_W-1:0] f;
        f[55:45] = raw1;
        f[44:34] = raw2;
        f[33:23] = raw3;
        f[22:21] = sw1;
        f[20:19] = sw2;
        f[18:17] = junk[10:9];
        f[16:15] = sw4;
        f[14:13] = junk[8:7];
        f[12:8]  = {btn[0], btn[1], btn[2], btn[3], btn[4]};
        f[7]     = btn[5];
        f[6:0]   = junk[6:0];
        return f;
    endfunction

    function automatic logic [FRAME_W-1:0] random_frame();
        logic [63:0] w;
        w = {$urandom, $urandom};
        if ($urandom_range(0, 9) < 3)
            return w[FRAME_W-1:0];
        return make_frame(pick_stick(), pick_stick(), pick_stick(), w[1:0], w[3:2], w[5:4],
                          w[11:6], w[22:12]);
    endfunction

    task automatic send_frame(input logic [FRAME_W-1:0] f);
        int gap;
        gap = sender_calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        frame_bytes <= f;
        forever begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        tracker.take_frame(f);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        tracker.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic program_regs(input logic [CFG_W-1:0] slew,
                                input logic [CFG_W-1:0] trans,
                                input logic [CFG_W-1:0] yaw);
        write_reg(CFG_SLEW_STEP, slew);
        write_reg(CFG_TRANSLATION_SCALE, trans);
        write_reg(CFG_YAW_SCALE, yaw);
        write_reg(CFG_SPARE, CFG_W'($urandom));
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic random_frames(input int count);
        repeat (count) send_frame(random_frame());
        settle();
    endtask

    initial begin : receiver_stalls
        int stall_left;
        stall_left = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (pressure_req) begin
                pressure_req = 1'b0;
                stall_left = PRESSURE_CYCLES - 1;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
                stall_left = receiver_calm ? 0 : pick_gap();
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            tracker.match_output(velocity_x, velocity_y, velocity_yaw, chassis_mode,
                                 test_submode, button_bits);
    end

    initial begin
        #5000000;
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_SLEW_STEP;
        cfg_data      = '0;
        in_valid      = 1'b0;
        frame_bytes   = '0;
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        pressure_req  = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset register values; sticks at rest, full throw both ways, and off-center by one.
        send_frame(make_frame(11'd660, 11'd660, 11'd660, SW_NONE, SW_NONE, SW_NONE, 6'h00, 11'h000));
        send_frame(make_frame(11'd0, 11'd2047, 11'd0, SW_UP, SW_UP, SUB_CLIMB, 6'h3F, 11'h7FF));
        send_frame(make_frame(11'd0, 11'd2047, 11'd0, SW_DOWN, SW_DOWN, SW_NONE, 6'h00, 11'h000));
        send_frame(make_frame(11'd0, 11'd2047, 11'd0, SW_UP, SW_DOWN, SW_NONE, 6'h15, 11'h555));
        send_frame(make_frame(11'd0, 11'd2047, 11'd0, SW_DOWN, SW_UP, SUB_DOWN, 6'h2A, 11'h2AA));
        send_frame(make_frame(11'd0, 11'd2047, 11'd0, SW_MID, SW_MID, SW_NONE, 6'h00, 11'h000));
        send_frame(make_frame(11'd0, 11'd2047, 11'd0, SW_NONE, SW_UP, SW_NONE, 6'h00, 11'h000));
        send_frame(make_frame(11'd2047, 11'd0, 11'd2047, SW_UP, SW_NONE, SUB_UP, 6'h00, 11'h000));
        send_frame(make_frame(11'd2047, 11'd0, 11'd2047, SW_MID, SW_UP, SW_NONE, 6'h00, 11'h000));
        send_frame(make_frame(11'd2047, 11'd0, 11'd2047, SW_UP, SW_MID, SW_NONE, 6'h00, 11'h000));
        send_frame(make_frame(11'd2047, 11'd0, 11'd2047, SW_DOWN, SW_MID, SW_NONE, 6'h00, 11'h000));
        send_frame(make_frame(11'd659, 11'd661, 11'd661, SW_UP, SW_UP, SW_NONE, 6'h01, 11'h000));
        send_frame(make_frame(11'd661, 11'd659, 11'd659, SW_UP, SW_UP, SW_NONE, 6'h02, 11'h000));
        send_frame(make_frame(11'd1320, 11'd0, 11'd1320, SW_NONE, SW_NONE, SUB_CLIMB, 6'h04, 11'h7FF));
        send_frame(make_frame(11'd0, 11'd1320, 11'd0, SW_NONE, SW_NONE, SW_NONE, 6'h08, 11'h000));
        send_frame(make_frame(11'd660, 11'd660, 11'd660, SW_NONE, SW_NONE, SUB_DOWN, 6'h10, 11'h000));
        send_frame(make_frame(11'd660, 11'd660, 11'd660, SW_NONE, SW_NONE, SW_NONE, 6'h20, 11'h000));
        send_frame(make_frame(11'd660, 11'd660, 11'd660, SW_NONE, SW_NONE, SW_NONE, 6'h00, 11'h000));
        settle();

        program_regs(15'd0, 15'd4095, 15'd4095);
        random_frames(60);

        program_regs(15'd32767, 15'd4095, 15'd4095);
        sender_calm  = 1'b1;
        pressure_req = 1'b1;
        random_frames(150);
        sender_calm = 1'b0;

        program_regs(15'd32767, 15'd0, 15'd0);
        sender_calm   = 1'b1;
        receiver_calm = 1'b1;
        random_frames(60);
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;

        program_regs(CFG_W'($urandom_range(1, 2000)), CFG_W'($urandom_range(0, 4095)),
                     CFG_W'($urandom_range(0, 4095)));
        random_frames(180);

        program_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
        random_frames(180);

        program_regs(CFG_W'($urandom_range(1, 300)), 15'd3000, 15'd5);
        random_frames(170);

        if (tracker.failures() == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
